// ===== rtl/bounded_list_engine_core_assert.svh =====
// Assertion macros used by the checker file of the bounded list engine.
`ifndef BOUNDED_LIST_ENGINE_CORE_ASSERT_SVH
`define BOUNDED_LIST_ENGINE_CORE_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define BLE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bounded_list_engine_core: same-cycle check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define BLE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bounded_list_engine_core: next-cycle check failed");

`endif

// ===== rtl/ble_pkg.sv =====
// Shared types, field widths, operation codes and status codes of the bounded list engine.
package ble_pkg;

    localparam int DEPTH_DEFAULT      = 16;
    localparam int DATA_WIDTH_DEFAULT = 32;

    localparam int OP_W     = 4;
    localparam int POS_W    = 4;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int HIT_W    = 4;
    localparam int READ_W   = 32;
    localparam int COUNT_W  = 5;
    localparam int SUM_W    = 36;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 4'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 4'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 4'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 4'd3;
    localparam logic [OP_W-1:0] OP_READ       = 4'd4;
    localparam logic [OP_W-1:0] OP_WRITE      = 4'd5;
    localparam logic [OP_W-1:0] OP_CONTAINS   = 4'd6;
    localparam logic [OP_W-1:0] OP_FIRST_GT   = 4'd7;
    localparam logic [OP_W-1:0] OP_CLEAR      = 4'd8;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INDEX = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]           op;
        logic [POS_W-1:0]          position;
        logic signed [VALUE_W-1:0] value;
    } cmd_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic                      found;
        logic [HIT_W-1:0]          hit_index;
        logic signed [READ_W-1:0]  read_data;
        logic [COUNT_W-1:0]        count;
        logic signed [SUM_W-1:0]   total;
    } rsp_item_t;

endpackage

// ===== rtl/ble_stream_if.sv =====
// Valid/ready channel interface that carries one item of a given payload type.
interface ble_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/bounded_list_engine_core.sv =====
// Top level of the bounded list engine: a double-ended queue held in a ring memory.
// Push, clear and refused items pass the done state, then the output register; one item at a time.
// Pop, read and write read the memory first, in the read state, before the done state.
// Searches read one entry per cycle from the front, until a hit or the last entry.
// Reset empties the list at once; the memory holds no valid data until it is written.
module bounded_list_engine_core #(
    parameter int DEPTH      = ble_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = ble_pkg::DATA_WIDTH_DEFAULT
) (
    input logic            clk,
    input logic            rst_n,
    ble_stream_if.sink     cmd,
    ble_stream_if.source   rsp
);
    import ble_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W:0]   DEPTH_EXT = (PTR_W + 1)'(DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]                   state_reg, state_next;
    logic [PTR_W-1:0]             head_reg, head_next;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic [SUM_W-1:0]             sum_reg, sum_next;
    logic                         out_valid_reg, out_valid_next;

    logic [OP_W-1:0]              op_reg, op_next;
    logic signed [DATA_WIDTH-1:0] val_reg, val_next;
    logic [PTR_W-1:0]             addr_reg, addr_next;
    logic [PTR_W-1:0]             scan_idx_reg, scan_idx_next;
    logic [STATUS_W-1:0]          status_reg, status_next;
    logic                         found_reg, found_next;
    logic [HIT_W-1:0]             hit_reg, hit_next;
    logic signed [READ_W-1:0]     rdat_reg, rdat_next;
    rsp_item_t                    out_data_reg, out_data_next;

    logic                         ram_en;
    logic                         ram_we;
    logic [PTR_W-1:0]             ram_addr;
    logic [DATA_WIDTH-1:0]        ram_wdata;
    logic [DATA_WIDTH-1:0]        ram_rdata;

    logic signed [DATA_WIDTH-1:0] in_val;
    logic signed [DATA_WIDTH-1:0] mem_val;
    logic signed [SUM_W-1:0]      in_ext;
    logic signed [SUM_W-1:0]      mem_ext;
    logic signed [SUM_W-1:0]      val_ext;
    logic                         pos_ok;
    logic                         list_full;
    logic                         list_empty;
    logic                         scan_hit;

    function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] base,
                                                  input logic [PTR_W-1:0] ofs);
        logic [PTR_W:0] s;
        s = {1'b0, base} + {1'b0, ofs};
        if (s >= DEPTH_EXT)
        begin
            s = s - DEPTH_EXT;
        end
        return s[PTR_W-1:0];
    endfunction

    function automatic logic [PTR_W-1:0] ring_inc(input logic [PTR_W-1:0] p);
        return (p == LAST_PTR) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic logic [PTR_W-1:0] ring_dec(input logic [PTR_W-1:0] p);
        return (p == '0) ? LAST_PTR : p - PTR_W'(1);
    endfunction

    ble_ram #(
        .DEPTH (DEPTH),
        .WIDTH (DATA_WIDTH)
    ) u_ble_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign in_val     = DATA_WIDTH'($signed(cmd.data.value));
    assign mem_val    = $signed(ram_rdata);
    assign in_ext     = SUM_W'(in_val);
    assign mem_ext    = SUM_W'(mem_val);
    assign val_ext    = SUM_W'(val_reg);
    assign pos_ok     = int'(cmd.data.position) < int'(count_reg);
    assign list_full  = (count_reg == FULL_CNT);
    assign list_empty = (count_reg == '0);
    assign scan_hit   = (op_reg == OP_FIRST_GT) ? (mem_val > val_reg) : (mem_val == val_reg);

    assign cmd.ready = (state_reg == S_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg;
        op_next        = op_reg;
        val_next       = val_reg;
        addr_next      = addr_reg;
        scan_idx_next  = scan_idx_reg;
        status_next    = status_reg;
        found_next     = found_reg;
        hit_next       = hit_reg;
        rdat_next      = rdat_reg;
        out_data_next  = out_data_reg;
        ram_en         = 1'b0;
        ram_we         = 1'b0;
        ram_addr       = head_reg;
        ram_wdata      = in_val;

        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    op_next     = cmd.data.op;
                    val_next    = in_val;
                    status_next = ST_OK;
                    found_next  = 1'b0;
                    hit_next    = '0;
                    rdat_next   = '0;
                    state_next  = S_DONE;
                    case (cmd.data.op)
                        OP_PUSH_FRONT, OP_PUSH_BACK:
                        begin
                            if (list_full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                ram_en = 1'b1;
                                ram_we = 1'b1;
                                if (cmd.data.op == OP_PUSH_FRONT)
                                begin
                                    ram_addr  = ring_dec(head_reg);
                                    head_next = ring_dec(head_reg);
                                end
                                else
                                begin
                                    ram_addr = ring_add(head_reg, PTR_W'(count_reg));
                                end
                                count_next = count_reg + CNT_W'(1);
                                sum_next   = sum_reg + in_ext;
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK:
                        begin
                            if (list_empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                ram_en = 1'b1;
                                if (cmd.data.op == OP_POP_BACK)
                                begin
                                    ram_addr = ring_add(head_reg,
                                                        PTR_W'(count_reg - CNT_W'(1)));
                                end
                                state_next = S_RD;
                            end
                        end
                        OP_READ, OP_WRITE:
                        begin
                            if (!pos_ok)
                            begin
                                status_next = ST_INDEX;
                            end
                            else
                            begin
                                ram_en     = 1'b1;
                                ram_addr   = ring_add(head_reg, PTR_W'(cmd.data.position));
                                addr_next  = ring_add(head_reg, PTR_W'(cmd.data.position));
                                state_next = S_RD;
                            end
                        end
                        OP_CONTAINS, OP_FIRST_GT:
                        begin
                            if (!list_empty)
                            begin
                                ram_en        = 1'b1;
                                addr_next     = head_reg;
                                scan_idx_next = '0;
                                state_next    = S_SCAN;
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next = '0;
                            head_next  = '0;
                            sum_next   = '0;
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_RD:
            begin
                state_next = S_DONE;
                case (op_reg)
                    OP_POP_FRONT:
                    begin
                        sum_next   = sum_reg - mem_ext;
                        head_next  = ring_inc(head_reg);
                        count_next = count_reg - CNT_W'(1);
                    end
                    OP_POP_BACK:
                    begin
                        sum_next   = sum_reg - mem_ext;
                        count_next = count_reg - CNT_W'(1);
                    end
                    OP_READ:
                    begin
                        rdat_next = READ_W'(mem_val);
                    end
                    OP_WRITE:
                    begin
                        sum_next  = sum_reg - mem_ext + val_ext;
                        ram_en    = 1'b1;
                        ram_we    = 1'b1;
                        ram_addr  = addr_reg;
                        ram_wdata = val_reg;
                    end
                    default:
                    begin
                        status_next = status_reg;
                    end
                endcase
            end
            S_SCAN:
            begin
                if (scan_hit)
                begin
                    found_next = 1'b1;
                    if (op_reg == OP_FIRST_GT)
                    begin
                        hit_next = HIT_W'(scan_idx_reg);
                    end
                    state_next = S_DONE;
                end
                else if (CNT_W'(scan_idx_reg) == count_reg - CNT_W'(1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    ram_en        = 1'b1;
                    ram_addr      = ring_inc(addr_reg);
                    addr_next     = ring_inc(addr_reg);
                    scan_idx_next = scan_idx_reg + PTR_W'(1);
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next          = 1'b1;
                    out_data_next.status    = status_reg;
                    out_data_next.found     = found_reg;
                    out_data_next.hit_index = hit_reg;
                    out_data_next.read_data = rdat_reg;
                    out_data_next.count     = COUNT_W'(count_reg);
                    out_data_next.total     = sum_reg;
                    state_next              = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        val_reg      <= val_next;
        addr_reg     <= addr_next;
        scan_idx_reg <= scan_idx_next;
        status_reg   <= status_next;
        found_reg    <= found_next;
        hit_reg      <= hit_next;
        rdat_reg     <= rdat_next;
        out_data_reg <= out_data_next;
    end
endmodule

// ===== rtl/ble_ram.sv =====
// Single-port synchronous memory with a registered read port.
module ble_ram #(
    parameter int DEPTH = ble_pkg::DEPTH_DEFAULT,
    parameter int WIDTH = ble_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== rtl/ble_checker.sv =====
// Port-level assertion checker for the bounded list engine and its bind statement.
`include "bounded_list_engine_core_assert.svh"

module ble_checker #(
    parameter int DEPTH = ble_pkg::DEPTH_DEFAULT
) (
    input logic              clk,
    input logic              rst_n,
    input logic              cmd_valid,
    input logic              cmd_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input ble_pkg::rsp_item_t rsp_data
);
    import ble_pkg::*;

    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(DEPTH);

    logic rsp_full;

    assign rsp_full = rsp_valid && (rsp_data.status == ST_FULL);

    // The engine works on one item at a time, so it stops taking items right after one.
    `BLE_ASSERT_NXT(a_one_at_a_time, clk, rst_n, cmd_valid && cmd_ready, !cmd_ready)
    `BLE_ASSERT_NXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid)
    `BLE_ASSERT_NXT(a_rsp_stable, clk, rst_n, rsp_valid && !rsp_ready, $stable(rsp_data))
    `BLE_ASSERT_IMP(a_full_count, clk, rst_n, rsp_full, rsp_data.count == FULL_COUNT)
endmodule

bind bounded_list_engine_core ble_checker #(
    .DEPTH (DEPTH)
) u_ble_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);
